/* rtl/core/clr_pkg.sv */
// Shared types and constants for the conditional layer resolver.
package clr_pkg;

    // Width of a layer mask on the ports.
    localparam int MASK_W = 32;

    // Width of a then-layer number inside a rule.
    localparam int THEN_W = 5;

    // Width of one rule register.
    localparam int RULE_W = 38;

    // Width of the configuration register index (eight rule registers).
    localparam int CFG_IDX_W = 3;

    // One rule register as it is written on the configuration port.
    typedef struct packed {
        logic              en;
        logic [THEN_W-1:0] target_layer;
        logic [MASK_W-1:0] if_mask;
    } rule_t;

endpackage

/* rtl/core/conditional_layer_resolver.sv */
// Conditional layer resolver: rule table memory and pass sequencer.
//
//   Channel  Handshake             Payload
//   -------  --------------------  ------------------------------------
//   input    start / busy          layer_mask_in
//   result   done (strobe)         layer_mask_out, settled
//   config   cfg_valid / cfg_ready cfg_index, cfg_data
//
// Rules sit in a one-port-read memory; one rule is read per cycle, and a pass
// is RULES reads followed by an evaluate step.
// An item runs for at most MAX_PASSES passes from start to done.
// Reset clears the sequencer and the per-rule valid bits; an unwritten rule
// reads as disabled. cfg_ready is always high.
// The result is shown for one cycle on done and cannot be stalled.
module conditional_layer_resolver #(
    parameter int RULES      = 8,
    parameter int LAYERS     = 32,
    parameter int MAX_PASSES = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            start,
    output logic                            busy,
    input  logic [clr_pkg::MASK_W-1:0]      layer_mask_in,

    output logic                            done,
    output logic [clr_pkg::MASK_W-1:0]      layer_mask_out,
    output logic                            settled,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [clr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [clr_pkg::RULE_W-1:0]      cfg_data
);

    localparam int RULE_AW = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int PASS_W  = $clog2(MAX_PASSES + 1);
    localparam logic [clr_pkg::MASK_W-1:0] LAYER_SPACE =
        clr_pkg::MASK_W'((64'd1 << LAYERS) - 64'd1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EVAL = 3'b100
    } state_t;

    // Rule memory and its read port.
    clr_pkg::rule_t                mem [RULES];
    logic [RULES-1:0]              valid_reg;
    clr_pkg::rule_t                rd_data_reg;
    logic                          rd_hit_reg;
    logic                          data_vld_reg;

    // Sequencer state.
    state_t                        state_reg, state_next;
    logic [RULE_AW-1:0]            idx_reg, idx_next;
    logic [PASS_W-1:0]             pass_reg, pass_next;
    logic [clr_pkg::MASK_W-1:0]    cur_reg, cur_next;
    logic [clr_pkg::MASK_W-1:0]    named_reg, named_next;
    logic [clr_pkg::MASK_W-1:0]    want_reg, want_next;

    // Result registers.
    logic                          done_reg, done_next;
    logic [clr_pkg::MASK_W-1:0]    out_mask_reg, out_mask_next;
    logic                          settled_reg, settled_next;

    // Contribution of the rule that came out of memory this cycle.
    logic                          rule_live;
    logic [clr_pkg::MASK_W-1:0]    rule_bit;
    logic [clr_pkg::MASK_W-1:0]    named_acc;
    logic [clr_pkg::MASK_W-1:0]    want_acc;
    logic [clr_pkg::MASK_W-1:0]    pass_mask;
    logic                          cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && ({1'b0, cfg_index} < (clr_pkg::CFG_IDX_W + 1)'(RULES));

    // Configuration writes go straight into the rule memory.
    always_ff @(posedge clk)
    begin
        if (cfg_we)
        begin
            mem[cfg_index[RULE_AW-1:0]] <= clr_pkg::rule_t'(cfg_data);
        end
    end

    // Synchronous read of the rule addressed by the scan index.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[idx_reg];
    end

    // Valid bits mark rules that were written since reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_hit_reg   <= 1'b0;
            data_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                valid_reg[cfg_index[RULE_AW-1:0]] <= 1'b1;
            end
            rd_hit_reg   <= valid_reg[idx_reg];
            data_vld_reg <= (state_reg == ST_SCAN);
        end
    end

    // Decode the rule read in the previous cycle and fold it into the pass.
    always_comb
    begin
        rule_live = data_vld_reg && rd_hit_reg && rd_data_reg.en &&
                    ({1'b0, rd_data_reg.target_layer} < (clr_pkg::THEN_W + 1)'(LAYERS));
        rule_bit  = clr_pkg::MASK_W'(1) << rd_data_reg.target_layer;
        named_acc = named_reg;
        want_acc  = want_reg;
        if (rule_live)
        begin
            named_acc = named_reg | rule_bit;
            if ((cur_reg & rd_data_reg.if_mask) == rd_data_reg.if_mask)
            begin
                want_acc = want_reg | rule_bit;
            end
        end
        pass_mask = ((cur_reg & ~named_acc) | (want_acc & named_acc)) & LAYER_SPACE;
    end

    // Pass sequencer.
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        pass_next     = pass_reg;
        cur_next      = cur_reg;
        named_next    = named_acc;
        want_next     = want_acc;
        done_next     = 1'b0;
        out_mask_next = out_mask_reg;
        settled_next  = settled_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                named_next = '0;
                want_next  = '0;
                if (start)
                begin
                    cur_next   = layer_mask_in & LAYER_SPACE;
                    idx_next   = '0;
                    pass_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == RULE_AW'(RULES - 1))
                begin
                    state_next = ST_EVAL;
                end
                else
                begin
                    idx_next = idx_reg + RULE_AW'(1);
                end
            end
            ST_EVAL:
            begin
                named_next = '0;
                want_next  = '0;
                idx_next   = '0;
                if (pass_mask == cur_reg)
                begin
                    done_next     = 1'b1;
                    out_mask_next = cur_reg;
                    settled_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (pass_reg == PASS_W'(MAX_PASSES - 1))
                begin
                    done_next     = 1'b1;
                    out_mask_next = pass_mask;
                    settled_next  = 1'b0;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cur_next   = pass_mask;
                    pass_next  = pass_reg + PASS_W'(1);
                    state_next = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            pass_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pass_reg  <= pass_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        named_reg    <= named_next;
        want_reg     <= want_next;
        out_mask_reg <= out_mask_next;
        settled_reg  <= settled_next;
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign layer_mask_out = out_mask_reg;
    assign settled        = settled_reg;

endmodule

/* rtl/core/clr_checker.sv */
// Port-level checks for the conditional layer resolver, bound into each instance of it.
module clr_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // An accepted transaction makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("busy not raised after an accepted transaction");

    // A result is never shown while work is still in progress.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe seen while busy");

    // The block leaves the busy phase exactly when it shows the result.
    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // Each result comes from a busy phase that just ended.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result without a preceding busy phase");

    // The strobe lasts one cycle only.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held for more than one cycle");

endmodule

bind conditional_layer_resolver clr_checker u_clr_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
